### src/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants
// Widths, sentinel slots, status codes and sequencer states.
// ----------------------------------------------------------------------------
package ffha_pkg;
   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 8;
   localparam int ALIGN_BYTES  = 4;
   localparam int SLOTS        = MAX_BLOCKS + 2;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int OFF_W        = 25;
   localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
   localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] TAIL_SLOT = SLOT_W'(1);
   localparam logic [OFF_W-1:0]  SIZE_CAP  = 25'd16777216;
   localparam logic [OFF_W-1:0]  SIZE_MIN  = OFF_W'(2 * HEADER_BYTES);
   localparam logic [OFF_W-1:0]  HDR       = OFF_W'(HEADER_BYTES);
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NO_ROOM = 3'd1,
      ST_NO_GAP  = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_CHECK, S_ARD, S_AWAIT, S_AEVAL, S_ALINK,
      S_FRD, S_FWAIT, S_FEVAL, S_FHINT, S_FLINK, S_DONE
   } state_type;

   typedef struct packed {
      logic                  we;
      logic [SLOT_W-1:0]     waddr;
      logic [OFF_W-1:0]      woff;
      logic [OFF_W-1:0]      wlen;
      logic [SLOT_W-1:0]     wnext;
      logic [SLOT_W-1:0]     raddr;
   } tbl_ctl_type;
endpackage

### src/ffha_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if / ffha_csr_if: channel interfaces
// Valid/ready channels with payload.
// ----------------------------------------------------------------------------
interface ffha_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [23:0] alloc_size;
   logic [31:0] free_address;
   modport source (output valid, req_type, alloc_size, free_address, input ready);
   modport sink   (input valid, req_type, alloc_size, free_address, output ready);
endinterface

interface ffha_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] block_address;
   logic [24:0] bytes_used_out;
   logic [6:0]  block_count_out;
   modport source (output valid, status, block_address, bytes_used_out,
                   block_count_out, input ready);
   modport sink   (input valid, status, block_address, bytes_used_out,
                   block_count_out, output ready);
endinterface

interface ffha_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/ffha_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_ram: generic single-port-write RAM
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end
   assign rdata = rdata_ff;
endmodule

### src/ffha_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_table: block table
// Offset, length and link per slot; read data registered.
// ----------------------------------------------------------------------------
module ffha_table (
   input  logic                         clock,
   input  ffha_pkg::tbl_ctl_type        ctl,
   output logic [ffha_pkg::OFF_W-1:0]   roff,
   output logic [ffha_pkg::OFF_W-1:0]   rlen,
   output logic [ffha_pkg::SLOT_W-1:0]  rnext
);
   localparam int TW = 2 * ffha_pkg::OFF_W + ffha_pkg::SLOT_W;
   logic [TW-1:0] rdata;

   ffha_ram #(.WIDTH(TW), .DEPTH(ffha_pkg::SLOTS)) u_ram (
      .clock (clock),
      .we    (ctl.we),
      .waddr (ctl.waddr),
      .wdata ({ctl.woff, ctl.wlen, ctl.wnext}),
      .raddr (ctl.raddr),
      .rdata (rdata)
   );
   assign {roff, rlen, rnext} = rdata;
endmodule

### src/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit heap block allocator
// Keeps an address-ordered block list in a table RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//  req: one transfer per request (allocate or free). Ready only when idle.
//  rsp: one transfer per request: status, address, bytes in use, block count.
//  csr: register writes (index 0 base, 1 size); each write re-inits the list
//       to the two sentinels, head row then tail row.
// Sequence: an allocate does the size and table-full checks first (the
//  free slot is picked from the valid bits there), then walks the list from
//  the hint, with a table read, registered data and a gap compare per entry
//  visited, then relinks. A free fetches the head row, walks block by block,
//  then reads the hint offset and relinks. One request at a time; ready
//  returns the cycle after the response transfer. The single table read
//  port sets the rate.
// Reset: synchronous; heap_base 0, heap_size 65536, list holds sentinels.
// Stall: the result sits in the output register until rsp transfers; no new
//  request is accepted meanwhile.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
   input logic    clock,
   input logic    reset,
   ffha_req_if.sink   req,
   ffha_rsp_if.source rsp,
   ffha_csr_if.sink   csr
);
   localparam int SW = ffha_pkg::SLOT_W;
   localparam int OW = ffha_pkg::OFF_W;
   localparam int CW = ffha_pkg::CNT_W;

   ffha_pkg::state_type state_ff, state_in;
   logic [31:0]   base_ff, base_in;
   logic [OW-1:0] size_ff, size_in;
   logic [ffha_pkg::SLOTS-1:0] live_ff, live_in;
   logic [SW-1:0] hint_ff, hint_in, cur_ff, cur_in, prev_ff, prev_in;
   logic [SW-1:0] nx_ff, nx_in, fslot_ff, fslot_in;
   logic [OW-1:0] used_ff, used_in, need_ff, need_in, coff_ff, coff_in;
   logic [OW-1:0] clen_ff, clen_in, hoff_ff, hoff_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW:0]   steps_ff, steps_in;
   logic          init_ff, init_in, op_ff, op_in;
   logic [31:0]   faddr_ff, faddr_in;
   logic [2:0]    st_ff, st_in;
   logic [31:0]   addr_ff, addr_in;
   logic          init_tail_ff, init_tail_in;

   ffha_pkg::tbl_ctl_type ctl;
   logic [OW-1:0] roff, rlen;
   logic [SW-1:0] rnext;

   ffha_table u_table (.clock(clock), .ctl(ctl), .roff(roff), .rlen(rlen),
                       .rnext(rnext));

   logic [OW-1:0] eff_size;
   logic [OW-1:0] rounded;
   logic [OW:0]   gap;
   logic [31:0]   daddr;
   logic [SW-1:0] free_pick;
   logic          free_found;

   always_comb begin
      eff_size = size_ff;
      if (size_ff < ffha_pkg::SIZE_MIN) eff_size = ffha_pkg::SIZE_MIN;
      if (size_ff > ffha_pkg::SIZE_CAP) eff_size = ffha_pkg::SIZE_CAP;
   end

   // lowest free non-sentinel slot; priority encode over valid bits
   always_comb begin
      free_pick  = '0;
      free_found = 1'b0;
      for (int s = ffha_pkg::SLOTS - 1; s >= 2; s--) begin
         if (!live_ff[s]) begin
            free_pick  = SW'(s);
            free_found = 1'b1;
         end
      end
   end

   assign rounded = OW'(({1'b0, req.alloc_size} + 25'(ffha_pkg::ALIGN_BYTES - 1))
                        & ~25'(ffha_pkg::ALIGN_BYTES - 1));
   // gap between next block and end of used part of current
   assign gap   = {1'b0, roff} - {1'b0, coff_ff} - {1'b0, clen_ff};
   assign daddr = base_ff + 32'(roff) + 32'(ffha_pkg::HEADER_BYTES);

   assign req.ready = (state_ff == ffha_pkg::S_IDLE) && !csr.valid;
   assign csr.ready = (state_ff == ffha_pkg::S_IDLE);
   assign rsp.valid = (state_ff == ffha_pkg::S_DONE);
   assign rsp.status          = st_ff;
   assign rsp.block_address   = addr_ff;
   assign rsp.bytes_used_out  = used_ff;
   assign rsp.block_count_out = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::S_INIT;
         base_ff  <= '0;
         size_ff  <= 25'd65536;
         init_tail_ff <= 1'b0;
         live_ff  <= '0;
         hint_ff  <= ffha_pkg::HEAD_SLOT;
         used_ff  <= ffha_pkg::SIZE_MIN;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         size_ff  <= size_in;
         init_tail_ff <= init_tail_in;
         live_ff  <= live_in;
         hint_ff  <= hint_in;
         used_ff  <= used_in;
         cnt_ff   <= cnt_in;
      end
      cur_ff <= cur_in;   prev_ff <= prev_in;  nx_ff <= nx_in;
      fslot_ff <= fslot_in; need_ff <= need_in; coff_ff <= coff_in;
      clen_ff <= clen_in; hoff_ff <= hoff_in;  steps_ff <= steps_in;
      init_ff <= init_in; op_ff <= op_in;      faddr_ff <= faddr_in;
      st_ff <= st_in;     addr_ff <= addr_in;
   end

   always_comb begin
      state_in = state_ff; base_in = base_ff; size_in = size_ff;
      init_tail_in = init_tail_ff; live_in = live_ff; hint_in = hint_ff;
      used_in = used_ff; cnt_in = cnt_ff; cur_in = cur_ff; prev_in = prev_ff;
      nx_in = nx_ff; fslot_in = fslot_ff; need_in = need_ff; coff_in = coff_ff;
      clen_in = clen_ff; hoff_in = hoff_ff; steps_in = steps_ff;
      init_in = init_ff; op_in = op_ff; faddr_in = faddr_ff; st_in = st_ff;
      addr_in = addr_ff;
      ctl = '0;
      ctl.raddr = cur_ff;
      case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (csr.valid) begin
               case (csr.index)
                  ffha_pkg::CSR_BASE: base_in = csr.data;
                  ffha_pkg::CSR_SIZE: size_in = csr.data[OW-1:0];
                  default: ;
               endcase
               init_tail_in = 1'b0;
               state_in = ffha_pkg::S_INIT;
            end else if (req.valid) begin
               op_in    = req.req_type;
               faddr_in = req.free_address;
               need_in  = rounded + ffha_pkg::HDR;
               coff_in  = rounded;
               addr_in  = '0;
               steps_in = '0;
               state_in = ffha_pkg::S_CHECK;
            end
         end
         ffha_pkg::S_INIT: begin
            ctl.we = 1'b1;
            ctl.wlen = ffha_pkg::HDR;
            if (!init_tail_ff) begin
               ctl.waddr = ffha_pkg::HEAD_SLOT;
               ctl.woff  = '0;
               ctl.wnext = ffha_pkg::TAIL_SLOT;
               init_tail_in = 1'b1;
            end else begin
               ctl.waddr = ffha_pkg::TAIL_SLOT;
               ctl.woff  = eff_size - ffha_pkg::HDR;
               ctl.wnext = ffha_pkg::TAIL_SLOT;
               live_in = '0;
               live_in[0] = 1'b1;
               live_in[1] = 1'b1;
               hint_in = ffha_pkg::HEAD_SLOT;
               used_in = ffha_pkg::SIZE_MIN;
               cnt_in  = '0;
               state_in = ffha_pkg::S_IDLE;
            end
         end
         ffha_pkg::S_CHECK: begin
            if (op_ff) begin
               prev_in = ffha_pkg::HEAD_SLOT;
               cur_in  = ffha_pkg::HEAD_SLOT;
               init_in = 1'b1; // first read fetches head's link
               ctl.raddr = hint_ff;
               state_in = ffha_pkg::S_FRD;
            end else if (coff_ff > eff_size - used_ff) begin
               st_in = ffha_pkg::ST_NO_ROOM; state_in = ffha_pkg::S_DONE;
            end else if (cnt_ff >= CW'(ffha_pkg::MAX_BLOCKS) || !free_found) begin
               st_in = ffha_pkg::ST_FULL; state_in = ffha_pkg::S_DONE;
            end else begin
               fslot_in = free_pick;
               cur_in   = hint_ff;
               state_in = ffha_pkg::S_ARD;
            end
         end
         // allocate walk: read cur, then read its next, compare
         ffha_pkg::S_ARD: begin
            if (cur_ff == ffha_pkg::TAIL_SLOT ||
                steps_ff >= (SW+1)'(ffha_pkg::SLOTS)) begin
               st_in = ffha_pkg::ST_NO_GAP; state_in = ffha_pkg::S_DONE;
            end else begin
               ctl.raddr = cur_ff;
               state_in = ffha_pkg::S_AWAIT;
            end
         end
         ffha_pkg::S_AWAIT: begin
            coff_in = roff; clen_in = rlen; nx_in = rnext;
            ctl.raddr = rnext;
            state_in = ffha_pkg::S_AEVAL;
         end
         ffha_pkg::S_AEVAL: begin
            if (!gap[OW] && gap[OW-1:0] >= need_ff) begin
               ctl.we = 1'b1;
               ctl.waddr = fslot_ff;
               ctl.woff = coff_ff + clen_ff;
               ctl.wlen = need_ff;
               ctl.wnext = nx_ff;
               addr_in = base_ff + 32'(coff_ff + clen_ff) +
                         32'(ffha_pkg::HEADER_BYTES);
               state_in = ffha_pkg::S_ALINK;
            end else begin
               cur_in = nx_ff;
               steps_in = steps_ff + 1'b1;
               state_in = ffha_pkg::S_ARD;
            end
         end
         ffha_pkg::S_ALINK: begin
            ctl.we = 1'b1;
            ctl.waddr = cur_ff;
            ctl.woff = coff_ff; ctl.wlen = clen_ff; ctl.wnext = fslot_ff;
            live_in[fslot_ff] = 1'b1;
            hint_in = fslot_ff;
            used_in = used_ff + need_ff;
            cnt_in  = cnt_ff + 1'b1;
            st_in   = ffha_pkg::ST_OK;
            state_in = ffha_pkg::S_DONE;
         end
         // free walk: prev/cur; read cur gives its link and offset
         ffha_pkg::S_FRD: begin
            if (init_ff) begin
               ctl.raddr = cur_ff;
               state_in = ffha_pkg::S_FWAIT;
            end else if (cur_ff == ffha_pkg::TAIL_SLOT ||
                         steps_ff >= (SW+1)'(ffha_pkg::SLOTS)) begin
               st_in = ffha_pkg::ST_UNKNOWN; state_in = ffha_pkg::S_DONE;
            end else begin
               ctl.raddr = cur_ff;
               state_in = ffha_pkg::S_FWAIT;
            end
         end
         ffha_pkg::S_FWAIT: begin
            // first pass: registered data is hint row (read in S_CHECK) is
            // stale; use this cycle's output of cur read instead
            state_in = ffha_pkg::S_FEVAL;
            ctl.raddr = cur_ff;
         end
         ffha_pkg::S_FEVAL: begin
            if (init_ff) begin
               coff_in = roff; clen_in = rlen; nx_in = rnext;  // head row
               init_in = 1'b0;
               cur_in  = rnext;
               state_in = ffha_pkg::S_FRD;
            end else if (daddr == faddr_ff) begin
               coff_in = roff; clen_in = rlen; nx_in = rnext;
               ctl.raddr = hint_ff;
               state_in = ffha_pkg::S_FHINT;
            end else begin
               prev_in = cur_ff;
               coff_in = roff; clen_in = rlen; nx_in = rnext;
               cur_in = rnext;
               steps_in = steps_ff + 1'b1;
               state_in = ffha_pkg::S_FRD;
            end
            hoff_in = hoff_ff;
         end
         ffha_pkg::S_FHINT: begin
            ctl.raddr = hint_ff;
            state_in = ffha_pkg::S_FLINK;
         end
         ffha_pkg::S_FLINK: begin
            // roff holds hint offset; prev's row is rewritten with new link
            if (coff_ff <= roff) hint_in = prev_ff;
            used_in = used_ff - clen_ff;
            cnt_in  = cnt_ff - 1'b1;
            live_in[cur_ff] = 1'b0;
            st_in = ffha_pkg::ST_OK;
            prev_in = prev_ff;
            state_in = ffha_pkg::S_DONE;
            // link fix: prev row needs off/len; stored in hoff/need path
            ctl.we = 1'b1;
            ctl.waddr = prev_ff;
            ctl.woff = hoff_ff;
            ctl.wlen = need_ff;
            ctl.wnext = nx_ff;
         end
         ffha_pkg::S_DONE: begin
            if (rsp.ready) state_in = ffha_pkg::S_IDLE;
         end
         default: state_in = ffha_pkg::S_IDLE;
      endcase
      // keep prev row (offset/length) while walking the free list
      if (state_ff == ffha_pkg::S_FEVAL && !(daddr == faddr_ff)) begin
         hoff_in = roff;
         need_in = rlen;
      end
   end
endmodule
